[src/lphm_pkg.sv]
// ----------------------------------------------------------------------------
// lphm_pkg
// shared types and codes of the linear probing key to handle map
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int FOUND_W  = 32;
  localparam int TOTAL_W  = 10;
  localparam int LIMIT_W  = 10;
  localparam int STATUS_W = 3;
  localparam int OP_W     = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd768;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NULL      = 3'd1,
    STAT_DUP       = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_MISMATCH  = 3'd4,
    STAT_FULL      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_SHIFT,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [FOUND_W-1:0]  found;
    logic [TOTAL_W-1:0]  total;
  } res_t;

endpackage

[src/linear_probe_hash_map_core.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_map_core
// open-addressing key to handle map, linear probing, backward-shift removal
// flow: null inserts or removes and full inserts go from S_IDLE straight to
//   S_RESP; others walk the probe run in S_PROBE (plus the backward-shift scan
//   in S_SHIFT on a successful remove), one slot per cycle through the read
//   port; next item accepted in the cycle after the result is handed on
// reset: clearing pass over every slot of the slot memory, no items
//   accepted meanwhile, config writes taken as ever
// ----------------------------------------------------------------------------
module linear_probe_hash_map_core #(
  parameter int TABLE_SLOTS = 1024,
  parameter int KEY_BITS    = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lphm_pkg::OP_W-1:0]      in_operation,
  input  logic [KEY_BITS-1:0]            in_key,
  input  logic [HANDLE_BITS-1:0]         in_value_handle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lphm_pkg::STATUS_W-1:0]  out_status,
  output logic [lphm_pkg::FOUND_W-1:0]   out_found_value,
  output logic [lphm_pkg::TOTAL_W-1:0]   out_entry_total,
  input  logic                           cfg_wr_en,
  input  logic [lphm_pkg::LIMIT_W-1:0]   cfg_wr_data
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int WW = 1 + HANDLE_BITS + KEY_BITS;

  logic [lphm_pkg::LIMIT_W-1:0] max_entries_r;
  logic                 out_valid_r;
  lphm_pkg::res_t       out_res_r;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WW-1:0]        wr_data;
  logic [AW-1:0]        rd_addr;
  logic [WW-1:0]        rd_data;
  logic                 res_valid;
  logic                 res_ready;
  lphm_pkg::res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= lphm_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_entries_r <= cfg_wr_data;
    end
  end

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  lphm_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lphm_seq #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_operation),
    .in_key      (in_key),
    .in_hdl      (in_value_handle),
    .max_entries (max_entries_r),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_found_value = out_res_r.found;
  assign out_entry_total = out_res_r.total;

endmodule

[src/lphm_ram.sv]
// ----------------------------------------------------------------------------
// lphm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lphm_ram #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/lphm_seq.sv]
// ----------------------------------------------------------------------------
// lphm_seq
// probe, insert and backward-shift sequencer over the slot memory
// ----------------------------------------------------------------------------
module lphm_seq #(
  parameter int TABLE_SLOTS = 1024,
  parameter int KEY_BITS    = 64,
  parameter int HANDLE_BITS = 32,
  localparam int AW         = $clog2(TABLE_SLOTS),
  localparam int WW         = 1 + HANDLE_BITS + KEY_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lphm_pkg::OP_W-1:0]     in_op,
  input  logic [KEY_BITS-1:0]           in_key,
  input  logic [HANDLE_BITS-1:0]        in_hdl,
  input  logic [lphm_pkg::LIMIT_W-1:0]  max_entries,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [WW-1:0]                 wr_data,
  output logic [AW-1:0]                 rd_addr,
  input  logic [WW-1:0]                 rd_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lphm_pkg::res_t                res
);

  localparam int CW   = AW;
  localparam int LW   = lphm_pkg::LIMIT_W;
  localparam int CMPW = (CW > LW) ? CW : LW;
  localparam int FW   = lphm_pkg::FOUND_W;
  localparam int TW   = lphm_pkg::TOTAL_W;

  lphm_pkg::state_t  state_r, state_nxt;
  logic [lphm_pkg::OP_W-1:0] op_r, op_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [HANDLE_BITS-1:0] hdl_r, hdl_nxt;
  logic [AW-1:0]          probe_r, probe_nxt;
  logic [AW-1:0]          vac_r, vac_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  lphm_pkg::status_t      status_r, status_nxt;
  logic [FW-1:0]          found_r, found_nxt;

  logic                   rd_used;
  logic [HANDLE_BITS-1:0] rd_hdl;
  logic [KEY_BITS-1:0]    rd_key;
  logic [AW-1:0]          probe_inc;
  logic                   in_full;
  logic                   in_null;

  assign rd_used   = rd_data[WW-1];
  assign rd_hdl    = rd_data[KEY_BITS +: HANDLE_BITS];
  assign rd_key    = rd_data[KEY_BITS-1:0];
  assign probe_inc = probe_r + AW'(1);

  assign in_null = (in_hdl == '0);
  assign in_full = (CMPW'(cnt_r) >= CMPW'(max_entries)) || (cnt_r >= CW'(TABLE_SLOTS - 1));

  // true when k lies in the circular range (i, j]
  function automatic logic in_range(input logic [AW-1:0] k, input logic [AW-1:0] i,
                                    input logic [AW-1:0] j);
    logic r;
    if (i <= j) begin
      r = (i < k) && (k <= j);
    end else begin
      r = (k > i) || (k <= j);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lphm_pkg::S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    hdl_r    <= hdl_nxt;
    probe_r  <= probe_nxt;
    vac_r    <= vac_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    hdl_nxt    = hdl_r;
    probe_nxt  = probe_r;
    vac_nxt    = vac_r;
    clr_nxt    = clr_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    in_stall   = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = vac_r;
    wr_data    = '0;
    rd_addr    = probe_inc;
    res_valid  = 1'b0;

    unique case (state_r)
      lphm_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(TABLE_SLOTS - 1)) begin
          state_nxt = lphm_pkg::S_IDLE;
        end
      end

      lphm_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        rd_addr    = AW'(in_key);
        found_nxt  = '0;
        status_nxt = lphm_pkg::STAT_OK;
        if (in_valid) begin
          op_nxt    = in_op;
          key_nxt   = in_key;
          hdl_nxt   = in_hdl;
          probe_nxt = AW'(in_key);
          if ((in_op == lphm_pkg::OP_INSERT || in_op == lphm_pkg::OP_REMOVE) && in_null) begin
            status_nxt = lphm_pkg::STAT_NULL;
            state_nxt  = lphm_pkg::S_RESP;
          end else if (in_op == lphm_pkg::OP_INSERT && in_full) begin
            status_nxt = lphm_pkg::STAT_FULL;
            state_nxt  = lphm_pkg::S_RESP;
          end else begin
            state_nxt = lphm_pkg::S_PROBE;
          end
        end
      end

      lphm_pkg::S_PROBE: begin
        probe_nxt = probe_inc;
        if (!rd_used) begin
          probe_nxt = probe_r;
          state_nxt = lphm_pkg::S_RESP;
          if (op_r == lphm_pkg::OP_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = probe_r;
            wr_data = {1'b1, hdl_r, key_r};
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            status_nxt = lphm_pkg::STAT_NOT_FOUND;
          end
        end else if (rd_key == key_r) begin
          state_nxt = lphm_pkg::S_RESP;
          if (op_r == lphm_pkg::OP_INSERT) begin
            status_nxt = lphm_pkg::STAT_DUP;
          end else if (op_r == lphm_pkg::OP_REMOVE) begin
            if (rd_hdl != hdl_r) begin
              status_nxt = lphm_pkg::STAT_MISMATCH;
            end else begin
              cnt_nxt   = cnt_r - CW'(1);
              vac_nxt   = probe_r;
              state_nxt = lphm_pkg::S_SHIFT;
            end
          end else begin
            found_nxt = FW'(rd_hdl);
          end
        end
      end

      lphm_pkg::S_SHIFT: begin
        probe_nxt = probe_inc;
        if (!rd_used) begin
          wr_en     = 1'b1;
          wr_addr   = vac_r;
          wr_data   = '0;
          state_nxt = lphm_pkg::S_RESP;
        end else if (!in_range(AW'(rd_key), vac_r, probe_r)) begin
          wr_en   = 1'b1;
          wr_addr = vac_r;
          wr_data = rd_data;
          vac_nxt = probe_r;
        end
      end

      lphm_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = lphm_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lphm_pkg::S_IDLE;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.found  = found_r;
  assign res.total  = TW'(cnt_r);

endmodule

[sim/linear_probe_hash_map_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map_core_tb
// drives inserts, removes and lookups into the key to handle map and checks
// every result item against a shadow copy of the slot store that probes and
// closes gaps the same way; covers wraparound runs, backward shifts, the
// limit register at its extremes, a full table and back-pressure on both sides
// ----------------------------------------------------------------------------
class map_tracker;
  localparam int SLOTS  = 1024;
  localparam int SLOT_W = 10;

  logic [63:0]                   slot_key [SLOTS];
  logic [31:0]                   slot_handle [SLOTS];
  bit                            slot_used [SLOTS];
  int unsigned                   entry_count;
  logic [lphm_pkg::LIMIT_W-1:0]  entry_limit;
  lphm_pkg::res_t                pending_replies [$];
  int unsigned                   errors;

  function new();
    foreach (slot_used[s]) begin
      slot_used[s]   = 1'b0;
      slot_key[s]    = '0;
      slot_handle[s] = '0;
    end
    entry_count = 0;
    entry_limit = lphm_pkg::LIMIT_RESET;
    errors      = 0;
  endfunction

  function int unsigned next_slot(int unsigned s);
    return (s + 1) % SLOTS;
  endfunction

  // walks the probe run, gives the key's slot or the first free one
  function bit find_key(logic [63:0] key, output int unsigned where);
    int unsigned s;
    s = 32'(key[SLOT_W-1:0]);
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[s]) begin
        where = s;
        return 1'b0;
      end
      if (slot_key[s] == key) begin
        where = s;
        return 1'b1;
      end
      s = next_slot(s);
    end
    where = s;
    return 1'b0;
  endfunction

  // k in the circular range (i, j]
  function bit between(int unsigned k, int unsigned i, int unsigned j);
    if (i <= j) return (i < k) && (k <= j);
    return (k > i) || (k <= j);
  endfunction

  function void close_gap(int unsigned hole);
    int unsigned vacated;
    int unsigned scan;
    int unsigned home;
    vacated = hole;
    scan    = next_slot(hole);
    for (int n = 0; n < SLOTS && slot_used[scan]; n++) begin
      home = 32'(slot_key[scan][SLOT_W-1:0]);
      if (!between(home, vacated, scan)) begin
        slot_key[vacated]    = slot_key[scan];
        slot_handle[vacated] = slot_handle[scan];
        slot_used[vacated]   = 1'b1;
        slot_key[scan]       = '0;
        slot_handle[scan]    = '0;
        slot_used[scan]      = 1'b0;
        vacated              = scan;
      end
      scan = next_slot(scan);
    end
  endfunction

  function void note_request(logic [1:0] op, logic [63:0] key, logic [31:0] handle);
    lphm_pkg::res_t r;
    int unsigned where;
    r.status = lphm_pkg::STAT_OK;
    r.found  = '0;
    case (op)
      lphm_pkg::OP_INSERT: begin
        if (handle == '0) begin
          r.status = lphm_pkg::STAT_NULL;
        end else if (entry_count >= entry_limit || entry_count >= SLOTS - 1) begin
          r.status = lphm_pkg::STAT_FULL;
        end else if (find_key(key, where)) begin
          r.status = lphm_pkg::STAT_DUP;
        end else begin
          slot_key[where]    = key;
          slot_handle[where] = handle;
          slot_used[where]   = 1'b1;
          entry_count++;
        end
      end
      lphm_pkg::OP_REMOVE: begin
        if (handle == '0) begin
          r.status = lphm_pkg::STAT_NULL;
        end else if (!find_key(key, where)) begin
          r.status = lphm_pkg::STAT_NOT_FOUND;
        end else if (slot_handle[where] != handle) begin
          r.status = lphm_pkg::STAT_MISMATCH;
        end else begin
          slot_key[where]    = '0;
          slot_handle[where] = '0;
          slot_used[where]   = 1'b0;
          entry_count--;
          close_gap(where);
        end
      end
      default: begin
        if (find_key(key, where)) r.found = slot_handle[where];
        else r.status = lphm_pkg::STAT_NOT_FOUND;
      end
    endcase
    r.total = entry_count[lphm_pkg::TOTAL_W-1:0];
    pending_replies.push_back(r);
  endfunction

  function void check_reply(logic [2:0] status, logic [31:0] found, logic [9:0] total);
    lphm_pkg::res_t want;
    if (pending_replies.size() == 0) begin
      $error("result item with no request outstanding: status %0d", status);
      errors++;
      return;
    end
    want = pending_replies.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      errors++;
    end
    if (found !== want.found) begin
      $error("found_value: expected %0h, got %0h", want.found, found);
      errors++;
    end
    if (total !== want.total) begin
      $error("entry_total: expected %0d, got %0d", want.total, total);
      errors++;
    end
  endfunction

  function bit pick_stored(output logic [63:0] key, output logic [31:0] handle);
    int unsigned s;
    key    = '0;
    handle = '0;
    if (entry_count == 0) return 1'b0;
    s = $urandom_range(SLOTS - 1);
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_used[s]) begin
        key    = slot_key[s];
        handle = slot_handle[s];
        return 1'b1;
      end
      s = next_slot(s);
    end
    return 1'b0;
  endfunction
endclass

module linear_probe_hash_map_core_tb;

  localparam int SLOTS            = 1024;
  localparam int KEY_W            = 64;
  localparam int HANDLE_W         = 32;
  localparam logic [lphm_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam int IDLE_PCT         = 8;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int SETTLE_CYCLES    = 20;
  localparam int SOFT_FILL        = 160;
  localparam int ITEMS_PER_PHASE  = 130;
  localparam int PHASES           = 6;
  localparam int WRAP_BASE        = 1016;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [lphm_pkg::OP_W-1:0]       in_operation;
  logic [KEY_W-1:0]                in_key;
  logic [HANDLE_W-1:0]             in_value_handle;
  logic                            out_valid;
  logic                            out_stall;
  logic [lphm_pkg::STATUS_W-1:0]   out_status;
  logic [lphm_pkg::FOUND_W-1:0]    out_found_value;
  logic [lphm_pkg::TOTAL_W-1:0]    out_entry_total;
  logic                            cfg_wr_en;
  logic [lphm_pkg::LIMIT_W-1:0]    cfg_wr_data;

  map_tracker            tracker;
  bit                    quiet;
  bit                    hold_off_req;
  int unsigned           cluster_base;

  linear_probe_hash_map_core #(
    .TABLE_SLOTS(SLOTS),
    .KEY_BITS(KEY_W),
    .HANDLE_BITS(HANDLE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_key(in_key),
    .in_value_handle(in_value_handle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_found_value(out_found_value),
    .out_entry_total(out_entry_total),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send(logic [lphm_pkg::OP_W-1:0] op, logic [KEY_W-1:0] key,
                      logic [HANDLE_W-1:0] handle);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_key          <= key;
    in_value_handle <= handle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(op, key, handle);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (tracker.pending_replies.size() != 0);
  endtask

  task automatic write_limit(logic [lphm_pkg::LIMIT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.entry_limit = value;
  endtask

  task automatic random_request();
    logic [lphm_pkg::OP_W-1:0] op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    stored_key;
    logic [HANDLE_W-1:0] stored_handle;
    bit                  have;
    int unsigned         r;
    int unsigned         insert_pct;
    have       = tracker.pick_stored(stored_key, stored_handle);
    insert_pct = (tracker.entry_count >= SOFT_FILL) ? 15 : 45;
    r = $urandom_range(99);
    if (r < insert_pct) op = lphm_pkg::OP_INSERT;
    else if (r < insert_pct + 30) op = lphm_pkg::OP_REMOVE;
    else if (r < 95) op = lphm_pkg::OP_LOOKUP;
    else op = OP_SPARE;

    r   = $urandom_range(99);
    key = {$urandom, $urandom};
    if (have && r < ((op == lphm_pkg::OP_INSERT) ? 20 : 55)) begin
      key = stored_key;
    end else if (have && r < ((op == lphm_pkg::OP_INSERT) ? 35 : 70)) begin
      key[9:0] = stored_key[9:0];
    end else if (r < 85) begin
      // keys crowded into a few neighboring home slots build long runs
      if ($urandom_range(1)) key[9:0] = 10'((WRAP_BASE + $urandom_range(15)) % SLOTS);
      else key[9:0] = 10'((cluster_base + $urandom_range(15)) % SLOTS);
    end

    r = $urandom_range(99);
    if (r < 5) handle = '0;
    else if (r < 9) handle = '1;
    else if (op == lphm_pkg::OP_REMOVE && have && key == stored_key && r < 80) begin
      handle = stored_handle;
    end else handle = $urandom;
    send(op, key, handle);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_reply(out_status, out_found_value, out_entry_total);
    end
  end

  // receiving side
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int unsigned stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("linear_probe_hash_map_core test failed");
    $finish;
  end

  initial begin
    logic [lphm_pkg::LIMIT_W-1:0] limits [PHASES];
    tracker         = new();
    quiet           = 1'b0;
    hold_off_req    = 1'b0;
    cluster_base    = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= lphm_pkg::OP_INSERT;
    in_key          <= '0;
    in_value_handle <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed items under the reset limit
    send(lphm_pkg::OP_LOOKUP, '0, '0);
    send(lphm_pkg::OP_REMOVE, '0, 32'h1);
    send(lphm_pkg::OP_REMOVE, '0, '0);
    send(lphm_pkg::OP_INSERT, 64'h1234, '0);
    send(lphm_pkg::OP_INSERT, '0, '1);
    send(lphm_pkg::OP_INSERT, '1, 32'h1);
    send(lphm_pkg::OP_INSERT, 64'h400, 32'h5A5A_A5A5);
    send(lphm_pkg::OP_INSERT, 64'h8000_0000_0000_03FF, 32'h8000_0000);
    send(lphm_pkg::OP_INSERT, '0, 32'h7);
    send(lphm_pkg::OP_LOOKUP, '1, '1);
    send(OP_SPARE, 64'h8000_0000_0000_03FF, '0);
    send(lphm_pkg::OP_LOOKUP, 64'h400, 32'h1);
    send(lphm_pkg::OP_REMOVE, '0, 32'h7);
    send(lphm_pkg::OP_REMOVE, '0, '1);
    send(lphm_pkg::OP_LOOKUP, 64'h8000_0000_0000_03FF, '0);
    send(lphm_pkg::OP_LOOKUP, 64'h400, '0);
    send(lphm_pkg::OP_REMOVE, '1, 32'h1);
    send(lphm_pkg::OP_LOOKUP, 64'h8000_0000_0000_03FF, '0);
    send(lphm_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FC00, '0);
    stop_sending();
    drain();
    // zero limit, null checked before full and full before duplicate
    write_limit('0);
    send(lphm_pkg::OP_INSERT, 64'h0123_4567_89AB_CDEF, '0);
    send(lphm_pkg::OP_INSERT, 64'h400, 32'h9);
    send(lphm_pkg::OP_INSERT, 64'h0123_4567_89AB_CDEF, 32'h9);

    limits[0] = 10'd1;
    limits[1] = 10'd8;
    limits[2] = '1;
    limits[3] = 10'($urandom_range(1022, 2));
    limits[4] = 10'd64;
    limits[5] = lphm_pkg::LIMIT_RESET;
    for (int p = 0; p < PHASES; p++) begin
      stop_sending();
      drain();
      write_limit(limits[p]);
      cluster_base = $urandom_range(SLOTS - 1);
      quiet = (p == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == 60) hold_off_req = 1'b1;
        random_request();
      end
      quiet = 1'b0;
    end

    stop_sending();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("linear_probe_hash_map_core test passed");
    end else begin
      $display("linear_probe_hash_map_core test failed");
    end
    $finish;
  end

endmodule
